FILE: rtl/spr_pkg.sv
// Package for the start-of-packet receiver: shared types and codes.
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

  // Beat kinds on the result stream
  localparam logic KindByte   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Input beat kinds
  localparam logic ModeByte = 1'b0;
  localparam logic ModeTick = 1'b1;

  // Packet status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusCheckErr = 2'd1;
  localparam logic [1:0] StatusAddrMiss = 2'd2;

  // Check modes
  localparam logic CheckSum = 1'b0;
  localparam logic CheckXor = 1'b1;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] RegStartByte  = 3'd0;
  localparam logic [2:0] RegPacketLen  = 3'd1;
  localparam logic [2:0] RegOwnAddr    = 3'd2;
  localparam logic [2:0] RegBcastAddr  = 3'd3;
  localparam logic [2:0] RegCheckMode  = 3'd4;
  localparam logic [2:0] RegTimeout    = 3'd5;

  localparam int unsigned ResultDataW = 32;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  frame_len;
    logic [7:0]  own_address;
    logic [7:0]  group_addr;
    logic        check_mode;
    logic [15:0] timeout_ticks;
  } spr_cfg_t;

  // One result beat
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [1:0] status;
    logic [7:0] computed_check;
  } spr_result_t;

  // Framing state exported for checking
  typedef struct packed {
    logic       collecting;
    logic [7:0] byte_count;
    logic [7:0] running_check;
  } spr_state_t;

endpackage : spr_pkg

`default_nettype wire

FILE: rtl/spr_cfg_regs.sv
// APB register file for the receiver configuration.
`timescale 1ns / 1ps
`default_nettype none

module spr_cfg_regs
  import spr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output spr_cfg_t         cfg_o
);

  spr_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegStartByte: cfg_d.start_byte    = pwdata[7:0];
        RegPacketLen: cfg_d.frame_len     = pwdata[7:0];
        RegOwnAddr:   cfg_d.own_address   = pwdata[7:0];
        RegBcastAddr: cfg_d.group_addr    = pwdata[7:0];
        RegCheckMode: cfg_d.check_mode    = pwdata[0];
        RegTimeout:   cfg_d.timeout_ticks = pwdata[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= 8'd0;
      cfg_q.frame_len     <= 8'd8;
      cfg_q.own_address   <= 8'd1;
      cfg_q.group_addr    <= 8'd255;
      cfg_q.check_mode    <= CheckSum;
      cfg_q.timeout_ticks <= 16'hFFFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      RegStartByte: prdata = {24'd0, cfg_q.start_byte};
      RegPacketLen: prdata = {24'd0, cfg_q.frame_len};
      RegOwnAddr:   prdata = {24'd0, cfg_q.own_address};
      RegBcastAddr: prdata = {24'd0, cfg_q.group_addr};
      RegCheckMode: prdata = {31'd0, cfg_q.check_mode};
      RegTimeout:   prdata = {16'd0, cfg_q.timeout_ticks};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule : spr_cfg_regs

`default_nettype wire

FILE: rtl/spr_core.sv
// Framing state, block check and timeout: one step per accepted beat.
`timescale 1ns / 1ps
`default_nettype none

module spr_core
  import spr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  spr_cfg_t         cfg_i,
  input  wire logic        beat_i,
  input  wire logic        mode_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  output spr_result_t      res_o,
  output spr_state_t       state_o
);

  logic        collecting_q, collecting_d;
  logic [7:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  check_q, check_d;
  logic        addr_ok_q, addr_ok_d;
  logic [15:0] ticks_q, ticks_d;

  logic [7:0]  pkt_len;
  logic        last_byte;
  logic        addr_hit;
  logic [7:0]  check_next;

  // Effective length, at least address plus check byte
  assign pkt_len    = (cfg_i.frame_len < 8'd2) ? 8'd2 : cfg_i.frame_len;
  assign last_byte  = ({1'b0, byte_cnt_q} + 9'd1) >= {1'b0, pkt_len};
  assign addr_hit   = (rx_byte_i == cfg_i.own_address) ||
                      (rx_byte_i == cfg_i.group_addr);
  assign check_next = (cfg_i.check_mode == CheckXor) ? (check_q ^ rx_byte_i)
                                                     : (check_q + rx_byte_i);

  // Next state and result
  always_comb begin
    collecting_d = collecting_q;
    byte_cnt_d   = byte_cnt_q;
    check_d      = check_q;
    addr_ok_d    = addr_ok_q;
    ticks_d      = ticks_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (beat_i) begin
      if (mode_i == ModeTick) begin
        // Timeout countdown, aborts silently on expiry
        if (collecting_q) begin
          if (ticks_q <= 16'd1) begin
            collecting_d = 1'b0;
            byte_cnt_d   = 8'd0;
            check_d      = 8'd0;
            addr_ok_d    = 1'b0;
            ticks_d      = 16'd0;
          end else begin
            ticks_d = ticks_q - 16'd1;
          end
        end
      end else if (!collecting_q) begin
        // Hunt for the start byte
        if (rx_byte_i == cfg_i.start_byte) begin
          collecting_d = 1'b1;
          byte_cnt_d   = 8'd0;
          check_d      = 8'd0;
          addr_ok_d    = 1'b0;
          ticks_d      = cfg_i.timeout_ticks;
        end
      end else begin
        ticks_d     = cfg_i.timeout_ticks;
        res_valid_o = 1'b1;
        if (last_byte) begin
          // Check byte: report status and return to hunting
          res_o.kind           = KindStatus;
          res_o.computed_check = check_q;
          if (!addr_ok_q) begin
            res_o.status = StatusAddrMiss;
          end else if (rx_byte_i != check_q) begin
            res_o.status = StatusCheckErr;
          end else begin
            res_o.status = StatusOk;
          end
          collecting_d = 1'b0;
          byte_cnt_d   = 8'd0;
          check_d      = 8'd0;
          addr_ok_d    = 1'b0;
        end else begin
          // Payload byte
          if (byte_cnt_q == 8'd0) begin
            addr_ok_d = addr_hit;
          end
          check_d          = check_next;
          res_o.kind       = KindByte;
          res_o.data_byte  = rx_byte_i;
          res_o.byte_index = byte_cnt_q;
          byte_cnt_d       = byte_cnt_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      byte_cnt_q   <= 8'd0;
      check_q      <= 8'd0;
      addr_ok_q    <= 1'b0;
      ticks_q      <= 16'hFFFF;
    end else begin
      collecting_q <= collecting_d;
      byte_cnt_q   <= byte_cnt_d;
      check_q      <= check_d;
      addr_ok_q    <= addr_ok_d;
      ticks_q      <= ticks_d;
    end
  end

  assign state_o.collecting    = collecting_q;
  assign state_o.byte_count    = byte_cnt_q;
  assign state_o.running_check = check_q;

endmodule : spr_core

`default_nettype wire

FILE: rtl/sop_packet_receiver_with_bcc.sv
// A result beat waits in the output register, or in the skid entry while stalled.
// Throughput: one input beat per cycle unless stalled; framing updates in one step.
// A two-entry output stage (result register plus skid) lets input flow on while a
// result waits; tready drops only when both entries are full.
// Reset: asynchronous, active low; hunting for start, registers at their defaults.
// Top level of the start-of-packet receiver with block check.
`timescale 1ns / 1ps
`default_nettype none

module sop_packet_receiver_with_bcc
  import spr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser_i,   // [0] mode
  // Result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [7:0] data_byte, [15:8] byte_index,
                                             // [17:16] status, [25:18] computed_check
  output logic             m_axis_tuser_o    // [0] kind
);

  spr_cfg_t    cfg;
  spr_result_t res;
  spr_state_t  core_state;
  logic        res_valid;
  logic        in_beat;

  spr_result_t out_q, out_d, skid_q, skid_d;
  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign pready          = 1'b1;
  assign s_axis_tready_o = ~skid_valid_q;
  assign in_beat         = s_axis_tvalid_i & s_axis_tready_o;

  spr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  spr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .beat_i      (in_beat),
    .mode_i      (s_axis_tuser_i),
    .rx_byte_i   (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .state_o     (core_state)
  );

  // Output register with skid entry
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_valid_q && !m_axis_tready_i) begin
      if (res_valid) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (skid_valid_q) begin
      out_d        = skid_q;
      out_valid_d  = 1'b1;
      skid_valid_d = 1'b0;
    end else begin
      out_d       = res;
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {6'd0, out_q.computed_check, out_q.status,
                            out_q.byte_index, out_q.data_byte};

  // Checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a beat while the output register is empty");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !core_state.collecting |-> (core_state.byte_count == 8'd0 &&
                                core_state.running_check == 8'd0))
    else $error("framing state not cleared while hunting for start");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KindStatus) |->
      (out_q.status == StatusOk || out_q.status == StatusCheckErr ||
       out_q.status == StatusAddrMiss))
    else $error("bad packet status code");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("result beat lost in output stage");

endmodule : sop_packet_receiver_with_bcc

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the start-of-packet receiver with block check.
`timescale 1ns / 1ps

module testbench;
  import spr_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdlePct    = 34;

  // One input beat: received byte or timer tick
  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } rx_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] rx_byte
  logic        s_axis_tuser_i = 1'b0; // [0] mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [7:0] data_byte, [15:8] byte_index,
                                      // [17:16] status, [25:18] computed_check
  logic        m_axis_tuser_o;        // [0] kind

  rx_event_t   rx_events[$];
  spr_result_t expected_beats[$];
  int unsigned events_queued = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;

  // Predictor copy of the registers and the framing state
  spr_cfg_t    link_cfg;
  logic        in_packet;
  logic [7:0]  byte_pos;
  logic [7:0]  running_bcc;
  logic        addr_match;
  logic [15:0] ticks_left;

  sop_packet_receiver_with_bcc u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Deframer prediction for one accepted beat
  function automatic void deframe_step(input logic mode, input logic [7:0] b);
    spr_result_t r;
    logic [8:0]  span;
    r = '0;
    span = (link_cfg.frame_len < 8'd2) ? 9'd2 : {1'b0, link_cfg.frame_len};
    if (mode == ModeTick) begin
      if (in_packet) begin
        if (ticks_left <= 16'd1) begin
          // timeout: drop the packet without a status
          in_packet   = 1'b0;
          byte_pos    = '0;
          running_bcc = '0;
          addr_match  = 1'b0;
          ticks_left  = '0;
        end else begin
          ticks_left = ticks_left - 16'd1;
        end
      end
    end else if (!in_packet) begin
      if (b == link_cfg.start_byte) begin
        in_packet   = 1'b1;
        byte_pos    = '0;
        running_bcc = '0;
        addr_match  = 1'b0;
        ticks_left  = link_cfg.timeout_ticks;
      end
    end else begin
      ticks_left = link_cfg.timeout_ticks;
      if ({1'b0, byte_pos} + 9'd1 >= span) begin
        // check byte: address miss outranks a bad check
        r.kind = KindStatus;
        if (!addr_match)
          r.status = StatusAddrMiss;
        else if (b != running_bcc)
          r.status = StatusCheckErr;
        else
          r.status = StatusOk;
        r.computed_check = running_bcc;
        in_packet   = 1'b0;
        byte_pos    = '0;
        running_bcc = '0;
        addr_match  = 1'b0;
      end else begin
        if (byte_pos == 8'd0)
          addr_match = (b == link_cfg.own_address) || (b == link_cfg.group_addr);
        running_bcc = (link_cfg.check_mode == CheckXor) ? (running_bcc ^ b)
                                                        : (running_bcc + b);
        r.kind       = KindByte;
        r.data_byte  = b;
        r.byte_index = byte_pos;
        byte_pos     = byte_pos + 8'd1;
      end
      expected_beats.push_back(r);
    end
  endfunction

  // Sender: feeds queued events, predicts on each accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        deframe_step(s_axis_tuser_i, s_axis_tdata_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (rx_events.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= rx_events[0].mode;
          s_axis_tdata_i  <= rx_events[0].rx_byte;
          void'(rx_events.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and result checking
  always @(posedge clk_i) begin
    spr_result_t got;
    spr_result_t want;
    m_axis_tready_i <= steady || ($urandom_range(99) >= IdlePct);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind           = m_axis_tuser_o;
      got.data_byte      = m_axis_tdata_o[7:0];
      got.byte_index     = m_axis_tdata_o[15:8];
      got.status         = m_axis_tdata_o[17:16];
      got.computed_check = m_axis_tdata_o[25:18];
      if (expected_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected beat: kind %0d byte %02h idx %0d st %0d bcc %02h",
                   got.kind, got.data_byte, got.byte_index, got.status,
                   got.computed_check);
      end else begin
        want = expected_beats.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp k%0d b%02h i%0d s%0d c%02h, got k%0d b%02h i%0d s%0d c%02h",
                     want.kind, want.data_byte, want.byte_index, want.status,
                     want.computed_check, got.kind, got.data_byte, got.byte_index,
                     got.status, got.computed_check);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_event(input logic mode, input logic [7:0] b);
    rx_event_t ev;
    ev.mode    = mode;
    ev.rx_byte = b;
    rx_events.push_back(ev);
    events_queued++;
  endtask

  task automatic push_ticks(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++)
      push_event(ModeTick, 8'($urandom));
  endtask

  // Start byte, address, payload and check; may be cut short by a timeout
  task automatic push_packet(input logic [7:0] addr, input bit bad_check,
                             input bit extreme_data, input bit allow_abort);
    int unsigned span;
    int unsigned cut;
    int unsigned n;
    int unsigned i;
    logic [7:0]  b;
    logic [7:0]  bcc;
    span = (link_cfg.frame_len < 8'd2) ? 2 : link_cfg.frame_len;
    cut = span;
    if (allow_abort && link_cfg.timeout_ticks <= 16'd64 && $urandom_range(7) == 0)
      cut = $urandom_range(span - 1);
    bcc = '0;
    push_event(ModeByte, link_cfg.start_byte);
    for (i = 0; i < span; i++) begin
      if (i == cut) begin
        push_ticks(link_cfg.timeout_ticks);
        return;
      end
      if (!extreme_data && link_cfg.timeout_ticks > 16'd1 && $urandom_range(4) == 0) begin
        n = (link_cfg.timeout_ticks > 16'd4) ? 3 : link_cfg.timeout_ticks - 1;
        push_ticks($urandom_range(n, 1));
      end
      if (i == span - 1)
        b = bad_check ? (bcc ^ 8'($urandom_range(255, 1))) : bcc;
      else if (i == 0)
        b = addr;
      else if (extreme_data)
        b = i[0] ? 8'hFF : 8'h00;
      else if ($urandom_range(19) == 0)
        b = link_cfg.start_byte;
      else
        b = 8'($urandom);
      if (i < span - 1)
        bcc = (link_cfg.check_mode == CheckXor) ? (bcc ^ b) : (bcc + b);
      push_event(ModeByte, b);
    end
  endtask

  // Random traffic: mostly well-formed packets, some idle noise
  task automatic push_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  b;
    logic [7:0]  addr;
    stop_at = events_queued + budget;
    while (events_queued < stop_at) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        push_event(ModeTick, 8'($urandom));
      end else if (pick == 1) begin
        // noise while hunting, never the start byte
        b = 8'($urandom);
        if (b == link_cfg.start_byte)
          b = ~b;
        push_event(ModeByte, b);
      end else begin
        pick = $urandom_range(9);
        if (pick < 4)
          addr = link_cfg.own_address;
        else if (pick < 7)
          addr = link_cfg.group_addr;
        else
          addr = 8'($urandom);
        push_packet(addr, $urandom_range(5) == 0, 1'b0, 1'b1);
      end
    end
  endtask

  // Wait for every beat to go in and every result to come out
  task automatic drain();
    while (rx_events.size() != 0 || s_axis_tvalid_i || expected_beats.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegStartByte: link_cfg.start_byte    = val[7:0];
      RegPacketLen: link_cfg.frame_len     = val[7:0];
      RegOwnAddr:   link_cfg.own_address   = val[7:0];
      RegBcastAddr: link_cfg.group_addr    = val[7:0];
      RegCheckMode: link_cfg.check_mode    = val[0];
      RegTimeout:   link_cfg.timeout_ticks = val[15:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [7:0] start, input logic [7:0] plen,
                           input logic [7:0] own, input logic [7:0] bcast,
                           input logic cmode, input logic [15:0] tmo,
                           input int unsigned budget, input bit no_idle);
    drain();
    write_reg(RegStartByte, {24'd0, start});
    write_reg(RegPacketLen, {24'd0, plen});
    write_reg(RegOwnAddr, {24'd0, own});
    write_reg(RegBcastAddr, {24'd0, bcast});
    write_reg(RegCheckMode, {31'd0, cmode});
    write_reg(RegTimeout, {16'd0, tmo});
    steady = no_idle;
    push_traffic(budget);
    drain();
    steady = 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    link_cfg.start_byte    = 8'd0;
    link_cfg.frame_len     = 8'd8;
    link_cfg.own_address   = 8'd1;
    link_cfg.group_addr    = 8'd255;
    link_cfg.check_mode    = CheckSum;
    link_cfg.timeout_ticks = 16'hFFFF;
    in_packet   = 1'b0;
    byte_pos    = '0;
    running_bcc = '0;
    addr_match  = 1'b0;
    ticks_left  = 16'hFFFF;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, idle noise, good packet with start byte and
    // extreme values as payload, address miss with bad check
    push_event(ModeTick, 8'hFF);
    push_event(ModeByte, 8'h5A);
    push_packet(8'h01, 1'b0, 1'b1, 1'b0);
    push_packet(8'h80, 1'b1, 1'b1, 1'b0);
    drain();
    push_traffic(100);

    // shortest packet, any tick aborts, XOR check
    run_phase(8'hA5, 8'd2, 8'h00, 8'hFF, CheckXor, 16'd1, 200, 1'b0);
    run_phase(8'hFF, 8'd5, 8'h7E, 8'h81, CheckSum, 16'd3, 200, 1'b0);
    // longest packet, keep the count low
    run_phase(8'h00, 8'd255, 8'hFF, 8'h00, CheckXor, 16'hFFFF, 280, 1'b0);
    // no stalls on either side
    run_phase(8'h3C, 8'd12, 8'h55, 8'hAA, CheckSum, 16'd40, 200, 1'b1);
    run_phase(8'h81, 8'd3, 8'h01, 8'hFF, CheckXor, 16'd2, 200, 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    fail_count += expected_beats.size();
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/spr_pkg.sv
rtl/spr_cfg_regs.sv
rtl/spr_core.sv
rtl/sop_packet_receiver_with_bcc.sv
test/testbench.sv
